// ----- rtl/neighbor_liveness_aging_table_assert.svh -----
// Assertion macros for the neighbour liveness aging table checker.
// No dependencies; the including scope must provide clk_i and rst_ni.
`ifndef NEIGHBOR_LIVENESS_AGING_TABLE_ASSERT_SVH
`define NEIGHBOR_LIVENESS_AGING_TABLE_ASSERT_SVH

// Plain property, sampled on the clock and disabled while in reset.
`define NLAT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NLAT_ASSERT_NEXT(label, ante, cons, msg) \
  `NLAT_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ----- rtl/nlat_pkg.sv -----
// Shared types and constants of the neighbour liveness aging table.
// No dependencies; used by every module of the block.
`default_nettype none

package nlat_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned MISS_W  = 8;
  localparam int unsigned PADDR_W = 3;

  // Item kinds.
  localparam logic [1:0] KIND_SEEN  = 2'd0;
  localparam logic [1:0] KIND_ROUND = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Status codes for a seen address.
  localparam logic [1:0] STATUS_REFRESH = 2'd0;
  localparam logic [1:0] STATUS_ADDED   = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  // Register index, taken from the word address bit of paddr.
  localparam logic REG_MAX_MISSES = 1'b0;

  localparam logic [MISS_W-1:0] MAX_MISSES_RESET = 8'd10;
  localparam logic [MISS_W-1:0] MISS_SAT         = 8'hFF;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [MISS_W-1:0] miss;
  } entry_t;

  typedef struct packed {
    logic              match;
    logic              free;
    logic              remove;
    logic [MISS_W-1:0] new_miss;
  } step_t;

endpackage

`default_nettype wire

// ----- rtl/nlat_store.sv -----
// Entry store: address and miss count per slot, one write and one read port.
// Depends on nlat_pkg for the entry type.
`default_nettype none

module nlat_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire nlat_pkg::entry_t wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output nlat_pkg::entry_t      rdata_o
);

  nlat_pkg::entry_t mem_q [DEPTH];
  nlat_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/nlat_step_unit.sv -----
// Shared per-slot unit: address compare, free test and miss count ageing.
// Depends on nlat_pkg for the entry and step result types.
`default_nettype none

module nlat_step_unit (
  input  wire logic [1:0]                  kind_i,
  input  wire logic                        valid_i,
  input  wire logic                        seen_i,
  input  wire nlat_pkg::entry_t            entry_i,
  input  wire logic [nlat_pkg::ADDR_W-1:0] peer_i,
  input  wire logic [nlat_pkg::MISS_W-1:0] max_misses_i,
  output nlat_pkg::step_t                  step_o
);

  logic [nlat_pkg::MISS_W-1:0] miss_inc;

  // The miss count saturates at its top value.
  assign miss_inc = (entry_i.miss == nlat_pkg::MISS_SAT) ? entry_i.miss
                                                         : entry_i.miss + 8'd1;

  always_comb begin
    step_o.match    = valid_i && (kind_i == nlat_pkg::KIND_SEEN) &&
                      (entry_i.addr == peer_i);
    step_o.free     = !valid_i;
    step_o.remove   = valid_i && (kind_i == nlat_pkg::KIND_ROUND) && !seen_i &&
                      (miss_inc > max_misses_i);
    step_o.new_miss = seen_i ? '0 : miss_inc;
  end

endmodule

`default_nettype wire

// ----- rtl/neighbor_liveness_aging_table.sv -----
// Top level of the neighbour liveness aging table: sequencer, flags and ports.
// Depends on nlat_pkg, nlat_store and nlat_step_unit.
//
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_ready_o    kind, peer_address, slot_index
//   out       output     out_valid_o / out_ready_i  status, slot_*, removed/live count
//   config    input      APB psel/penable/pready    max_misses at byte address 0
//
// An address seen or an end of round sweeps every slot through one shared
// compare and ageing unit, each slot in the cycle after its registered store
// read. A slot read goes through ST_READ and an unused kind straight to
// ST_FINISH, without a sweep.
// Reset clears all valid and seen flags at once, so no clearing pass is needed.
// A result waits in the output register while the next item is accepted; the
// sequencer only holds in its final state when that register is still full.
`default_nettype none

module neighbor_liveness_aging_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // Input items.
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic [1:0]                             kind_i,
  input  wire logic [nlat_pkg::ADDR_W-1:0]            peer_address_i,
  input  wire logic [3:0]                             slot_index_i,
  // Results.
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic [1:0]                                  status_o,
  output logic                                        slot_valid_o,
  output logic [nlat_pkg::ADDR_W-1:0]                 slot_address_o,
  output logic [nlat_pkg::MISS_W-1:0]                 slot_misses_o,
  output logic [4:0]                                  removed_count_o,
  output logic [4:0]                                  live_count_o,
  // Configuration port.
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [nlat_pkg::PADDR_W-1:0]           paddr,
  input  wire logic [31:0]                            pwdata,
  output logic [31:0]                                 prdata,
  output logic                                        pready
);

  // Slot index width, counter width (holds TABLE_DEPTH itself) and padding
  // widths used to move between those and the fixed port widths.
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned XW = (AW > 4) ? AW : 4;
  localparam int unsigned LW = (CW > 5) ? CW : 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_READ,
    ST_FINISH
  } state_e;

  state_e                        state_q;
  logic [1:0]                    kind_q;
  logic [nlat_pkg::ADDR_W-1:0]   peer_q;
  logic [AW-1:0]                 idx_q;
  logic                          in_range_q;
  logic [CW-1:0]                 issue_cnt_q;
  logic [AW-1:0]                 proc_idx_q;
  logic                          proc_valid_q;
  logic                          hit_q;
  logic [AW-1:0]                 hit_idx_q;
  logic                          free_found_q;
  logic [AW-1:0]                 free_idx_q;
  logic [CW-1:0]                 removed_q;
  logic [CW-1:0]                 live_q;
  logic [TABLE_DEPTH-1:0]        valid_q;
  logic [TABLE_DEPTH-1:0]        seen_q;
  logic [nlat_pkg::MISS_W-1:0]   max_misses_q;

  logic                          out_valid_q;
  logic [1:0]                    status_q;
  logic                          slot_valid_q;
  logic [nlat_pkg::ADDR_W-1:0]   slot_address_q;
  logic [nlat_pkg::MISS_W-1:0]   slot_misses_q;
  logic [4:0]                    removed_count_q;
  logic [4:0]                    live_count_q;

  logic                          in_xfer;
  logic                          out_free;
  logic                          issue;
  logic                          cfg_write;
  logic [XW-1:0]                 idx_ext;
  logic [AW-1:0]                 idx_in;
  logic                          idx_in_range;
  logic [AW-1:0]                 rd_addr;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  nlat_pkg::entry_t              wr_data;
  nlat_pkg::entry_t              rd_data;
  nlat_pkg::step_t               step;
  logic                          add_now;
  logic [CW-1:0]                 live_fin;
  logic [LW-1:0]                 live_fin_w;
  logic [LW-1:0]                 live_now_w;
  logic [LW-1:0]                 removed_w;
  logic                          read_hit;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign cfg_write  = psel && penable && pwrite;

  // APB side: always ready, one register in the word at address 0.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == nlat_pkg::REG_MAX_MISSES) ? {24'b0, max_misses_q} : '0;

  // The slot index of a read is widened or cut to the table's index width.
  // Out-of-range indices are stored as zero and flagged.
  assign idx_ext      = XW'(slot_index_i);
  assign idx_in_range = (32'(slot_index_i) < TABLE_DEPTH);
  assign idx_in       = idx_in_range ? idx_ext[AW-1:0] : '0;

  // The sweep issues a store read for slot issue_cnt_q and processes the
  // previous slot, whose data has just come out of the store. A slot read keeps
  // its own address on the store so that the data survives an output stall.
  assign issue   = (issue_cnt_q < CW'(TABLE_DEPTH));
  assign rd_addr = (state_q == ST_IDLE) ? idx_in
                 : (state_q == ST_READ) ? idx_q
                 : (issue ? issue_cnt_q[AW-1:0] : '0);

  nlat_store #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_nlat_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  nlat_step_unit u_nlat_step_unit (
    .kind_i       (kind_q),
    .valid_i      (valid_q[proc_idx_q]),
    .seen_i       (seen_q[proc_idx_q]),
    .entry_i      (rd_data),
    .peer_i       (peer_q),
    .max_misses_i (max_misses_q),
    .step_o       (step)
  );

  // A new address is placed once the sweep found no match but a free slot.
  assign add_now = (kind_q == nlat_pkg::KIND_SEEN) && !hit_q && free_found_q;

  // Store writes: the aged miss count during an end-of-round sweep, or the
  // new entry when the result of a seen address is handed to the output.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = proc_idx_q;
    wr_data = '{addr: rd_data.addr, miss: step.new_miss};
    if (state_q == ST_SWEEP && proc_valid_q && kind_q == nlat_pkg::KIND_ROUND &&
        valid_q[proc_idx_q]) begin
      wr_en = 1'b1;
    end else if (state_q == ST_FINISH && out_free && add_now) begin
      wr_en   = 1'b1;
      wr_addr = free_idx_q;
      wr_data = '{addr: peer_q, miss: '0};
    end
  end

  assign live_fin   = add_now ? live_q + CW'(1) : live_q;
  assign live_fin_w = LW'(live_fin);
  assign live_now_w = LW'(live_q);
  assign removed_w  = LW'(removed_q);
  assign read_hit   = in_range_q && valid_q[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      kind_q          <= nlat_pkg::KIND_SEEN;
      peer_q          <= '0;
      idx_q           <= '0;
      in_range_q      <= 1'b0;
      valid_q         <= '0;
      seen_q          <= '0;
      live_q          <= '0;
      removed_q       <= '0;
      issue_cnt_q     <= '0;
      proc_idx_q      <= '0;
      proc_valid_q    <= 1'b0;
      hit_q           <= 1'b0;
      hit_idx_q       <= '0;
      free_found_q    <= 1'b0;
      free_idx_q      <= '0;
      max_misses_q    <= nlat_pkg::MAX_MISSES_RESET;
      out_valid_q     <= 1'b0;
      status_q        <= nlat_pkg::STATUS_REFRESH;
      slot_valid_q    <= 1'b0;
      slot_address_q  <= '0;
      slot_misses_q   <= '0;
      removed_count_q <= '0;
      live_count_q    <= '0;
    end else begin
      if (cfg_write && pready && paddr[2] == nlat_pkg::REG_MAX_MISSES) begin
        max_misses_q <= pwdata[7:0];
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            kind_q       <= kind_i;
            peer_q       <= peer_address_i;
            idx_q        <= idx_in;
            in_range_q   <= idx_in_range;
            issue_cnt_q  <= '0;
            proc_valid_q <= 1'b0;
            hit_q        <= 1'b0;
            free_found_q <= 1'b0;
            removed_q    <= '0;
            case (kind_i)
              nlat_pkg::KIND_SEEN,
              nlat_pkg::KIND_ROUND: state_q <= ST_SWEEP;
              nlat_pkg::KIND_READ:  state_q <= ST_READ;
              default:              state_q <= ST_FINISH;
            endcase
          end
        end

        ST_SWEEP: begin
          proc_valid_q <= issue;
          proc_idx_q   <= issue_cnt_q[AW-1:0];
          if (issue) begin
            issue_cnt_q <= issue_cnt_q + CW'(1);
          end
          if (proc_valid_q) begin
            if (kind_q == nlat_pkg::KIND_SEEN) begin
              // Keep the lowest matching slot and the lowest free slot.
              if (step.match && !hit_q) begin
                hit_q     <= 1'b1;
                hit_idx_q <= proc_idx_q;
              end
              if (step.free && !free_found_q) begin
                free_found_q <= 1'b1;
                free_idx_q   <= proc_idx_q;
              end
            end else if (step.remove) begin
              valid_q[proc_idx_q] <= 1'b0;
              removed_q           <= removed_q + CW'(1);
              live_q              <= live_q - CW'(1);
            end
          end
          if (!proc_valid_q && !issue) begin
            state_q <= ST_FINISH;
          end
        end

        ST_READ: begin
          if (out_free) begin
            out_valid_q     <= 1'b1;
            status_q        <= nlat_pkg::STATUS_REFRESH;
            slot_valid_q    <= read_hit;
            slot_address_q  <= read_hit ? rd_data.addr : '0;
            slot_misses_q   <= read_hit ? rd_data.miss : '0;
            removed_count_q <= '0;
            live_count_q    <= live_now_w[4:0];
            state_q         <= ST_IDLE;
          end
        end

        ST_FINISH: begin
          if (out_free) begin
            out_valid_q     <= 1'b1;
            status_q        <= nlat_pkg::STATUS_REFRESH;
            slot_valid_q    <= 1'b0;
            slot_address_q  <= '0;
            slot_misses_q   <= '0;
            removed_count_q <= '0;
            live_count_q    <= live_fin_w[4:0];
            case (kind_q)
              nlat_pkg::KIND_SEEN: begin
                if (hit_q) begin
                  seen_q[hit_idx_q] <= 1'b1;
                end else if (free_found_q) begin
                  // A new entry counts as seen in the round it arrives.
                  valid_q[free_idx_q] <= 1'b1;
                  seen_q[free_idx_q]  <= 1'b1;
                  live_q              <= live_fin;
                  status_q            <= nlat_pkg::STATUS_ADDED;
                end else begin
                  status_q <= nlat_pkg::STATUS_FULL;
                end
              end
              nlat_pkg::KIND_ROUND: begin
                seen_q          <= '0;
                removed_count_q <= removed_w[4:0];
              end
              default: begin
              end
            endcase
            state_q <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign slot_valid_o    = slot_valid_q;
  assign slot_address_o  = slot_address_q;
  assign slot_misses_o   = slot_misses_q;
  assign removed_count_o = removed_count_q;
  assign live_count_o    = live_count_q;

endmodule

`default_nettype wire

// ----- rtl/nlat_checker.sv -----
// Port-level checker for the neighbour liveness aging table, with its bind.
// Depends on neighbor_liveness_aging_table_assert.svh for the assertion macros.
`default_nettype none

`include "neighbor_liveness_aging_table_assert.svh"

module nlat_checker #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  status_o,
  input wire logic        slot_valid_o,
  input wire logic [31:0] slot_address_o,
  input wire logic [7:0]  slot_misses_o,
  input wire logic [4:0]  removed_count_o,
  input wire logic [4:0]  live_count_o
);

  localparam int unsigned LiveLimit = (TABLE_DEPTH > 31) ? 31 : TABLE_DEPTH;

  // A result that is not taken holds still.
  `NLAT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(slot_address_o) && $stable(live_count_o), "result changed while stalled")

  // The block is never ready in the cycle after it accepts an item.
  `NLAT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready straight after a transfer")

  // The table never reports more live entries than it has slots.
  `NLAT_ASSERT(a_live_bound, out_valid_o |-> (32'(live_count_o) <= LiveLimit), "live count above table depth")

  // An empty slot read shows neither an address nor a miss count.
  `NLAT_ASSERT(a_empty_slot, out_valid_o && !slot_valid_o |-> slot_address_o == '0 && slot_misses_o == '0, "invalid slot with payload")

  // A non-zero status only comes from a seen address, which reads no slot and removes nothing.
  `NLAT_ASSERT(a_status_only, out_valid_o && status_o != nlat_pkg::STATUS_REFRESH |-> !slot_valid_o && removed_count_o == '0, "status mixed with other kinds")

endmodule

bind neighbor_liveness_aging_table nlat_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_nlat_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .slot_valid_o    (slot_valid_o),
  .slot_address_o  (slot_address_o),
  .slot_misses_o   (slot_misses_o),
  .removed_count_o (removed_count_o),
  .live_count_o    (live_count_o)
);

`default_nettype wire
